[hdl/rpd_pkg.sv]
// Package for the raw PCM16 block deframer.
// Holds the fixed limits, the status codes and the beat and result types.
// No dependencies.
`timescale 1ns / 1ps

package rpd_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_ELEMENTS = 16384;

    localparam int HEADER_BYTES = 8;
    localparam int COUNT_W      = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam int CAP_W = 15;
    localparam logic [CAP_W-1:0] CAP_RESET = 15'd16384;

    // Header field widths and the width of the channel-by-samples product.
    localparam int HCH_W   = 16;
    localparam int HFL_W   = 16;
    localparam int SMP_W   = 32;
    localparam int CH_W    = $clog2(MAX_CHANNELS + 1);
    localparam int PROD_W  = CH_W + SMP_W;
    localparam int CMP_W   = PROD_W + 2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TRUNCATED     = 3'd1,
        ST_PROFILE_BOUND = 3'd2,
        ST_UNSUPPORTED   = 3'd3,
        ST_MALFORMED     = 3'd4,
        ST_TOO_SMALL     = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        status_t            status;
        logic [3:0]         channel_count;
        logic [14:0]        per_channel_samples;
        logic [14:0]        element_total;
        logic               last;
    } res_item_t;

    // Up to two results come from one input beat: a sample, then the status.
    typedef struct packed {
        logic      sample_valid;
        res_item_t sample_item;
        logic      status_valid;
        res_item_t status_item;
    } res_pair_t;

endpackage

[hdl/rpd_if.sv]
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on rpd_pkg for the status type.
`timescale 1ns / 1ps

interface rpd_in_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_buffer, output ready);
endinterface

interface rpd_out_if import rpd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] sample;
    status_t            status;
    logic [3:0]         channel_count;
    logic [14:0]        per_channel_samples;
    logic [14:0]        element_total;
    logic               last;

    modport source (output valid, output kind, output sample, output status,
                    output channel_count, output per_channel_samples,
                    output element_total, output last, input ready);
    modport sink   (input valid, input kind, input sample, input status,
                    input channel_count, input per_channel_samples,
                    input element_total, input last, output ready);
endinterface

[hdl/rpd_core.sv]
// Per-buffer state of the deframer: header capture, sample pairing and status.
// Depends on rpd_pkg.
`timescale 1ns / 1ps

module rpd_core import rpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  in_item_t         item,
    input  logic [CAP_W-1:0] capacity,
    output res_pair_t        pair
);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [HCH_W-1:0]   hdr_channels_reg, hdr_channels_next;
    logic [HFL_W-1:0]   hdr_flags_reg, hdr_flags_next;
    logic [SMP_W-1:0]   hdr_samples_reg, hdr_samples_next;
    logic [7:0]         low_byte_hold_reg, low_byte_hold_next;

    logic               in_header;
    logic               in_body;
    logic [14:0]        pair_index;
    logic [PROD_W-1:0]  product;
    logic               in_bounds;
    logic [14:0]        elements_expected;
    logic               may_emit;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   expect_count;
    status_t            status;

    assign in_header = (byte_count_reg < COUNT_W'(HEADER_BYTES));
    assign in_body   = item.has_byte && !in_header && (byte_count_reg != COUNT_MAX);

    always_comb
    begin
        hdr_channels_next = hdr_channels_reg;
        hdr_flags_next    = hdr_flags_reg;
        hdr_samples_next  = hdr_samples_reg;
        if (item.has_byte && in_header)
        begin
            case (byte_count_reg[2:0])
                3'd0: hdr_channels_next[7:0]   = item.data_byte;
                3'd1: hdr_channels_next[15:8]  = item.data_byte;
                3'd2: hdr_flags_next[7:0]      = item.data_byte;
                3'd3: hdr_flags_next[15:8]     = item.data_byte;
                3'd4: hdr_samples_next[7:0]    = item.data_byte;
                3'd5: hdr_samples_next[15:8]   = item.data_byte;
                3'd6: hdr_samples_next[23:16]  = item.data_byte;
                3'd7: hdr_samples_next[31:24]  = item.data_byte;
                default: ;
            endcase
        end
    end

    assign byte_count_next = byte_count_reg +
        COUNT_W'(item.has_byte && (byte_count_reg != COUNT_MAX));

    assign low_byte_hold_next = (in_body && !byte_count_reg[0]) ? item.data_byte
                                                                : low_byte_hold_reg;

    // Only the low channel bits enter the product; the bound check rejects
    // any header whose channel count needs more.
    assign product = {{SMP_W{1'b0}}, hdr_channels_next[CH_W-1:0]} *
                     {{CH_W{1'b0}}, hdr_samples_next};

    assign in_bounds = (hdr_channels_next != '0) &&
                       (hdr_channels_next <= HCH_W'(MAX_CHANNELS)) &&
                       (hdr_samples_next != '0) &&
                       (product <= PROD_W'(MAX_ELEMENTS));

    assign elements_expected = in_bounds ? product[14:0] : 15'd0;
    assign may_emit = in_bounds && (hdr_flags_next == '0) &&
                      ({{(PROD_W-CAP_W){1'b0}}, capacity} >= product);

    // Body byte at an odd count closes a sample; its index among the samples.
    assign pair_index = byte_count_reg[COUNT_W-1:1] - 15'(HEADER_BYTES / 2);

    assign count_ext    = CMP_W'(byte_count_next);
    assign expect_count = {1'b0, product, 1'b0} + CMP_W'(HEADER_BYTES);

    always_comb
    begin
        if (byte_count_next < COUNT_W'(HEADER_BYTES))
            status = ST_TRUNCATED;
        else if (!in_bounds)
            status = ST_PROFILE_BOUND;
        else if (hdr_flags_next != '0)
            status = ST_UNSUPPORTED;
        else if (count_ext < expect_count)
            status = ST_TRUNCATED;
        else if (count_ext > expect_count)
            status = ST_MALFORMED;
        else if ({{(PROD_W-CAP_W){1'b0}}, capacity} < product)
            status = ST_TOO_SMALL;
        else
            status = ST_OK;
    end

    always_comb
    begin
        pair.sample_valid = in_body && byte_count_reg[0] && may_emit &&
                            (pair_index < elements_expected);
        pair.sample_item.kind                = KIND_SAMPLE;
        pair.sample_item.sample              = {item.data_byte, low_byte_hold_reg};
        pair.sample_item.status              = ST_OK;
        pair.sample_item.channel_count       = '0;
        pair.sample_item.per_channel_samples = '0;
        pair.sample_item.element_total       = '0;
        pair.sample_item.last                = 1'b0;

        pair.status_valid = item.end_of_buffer;
        pair.status_item.kind   = KIND_STATUS;
        pair.status_item.sample = '0;
        pair.status_item.status = status;
        pair.status_item.last   = 1'b1;
        if (status == ST_OK)
        begin
            pair.status_item.channel_count       = hdr_channels_next[3:0];
            pair.status_item.per_channel_samples = hdr_samples_next[14:0];
            pair.status_item.element_total       = product[14:0];
        end
        else
        begin
            pair.status_item.channel_count       = '0;
            pair.status_item.per_channel_samples = '0;
            pair.status_item.element_total       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            hdr_channels_reg  <= '0;
            hdr_flags_reg     <= '0;
            hdr_samples_reg   <= '0;
            low_byte_hold_reg <= '0;
        end
        else if (take)
        begin
            if (item.end_of_buffer)
            begin
                byte_count_reg    <= '0;
                hdr_channels_reg  <= '0;
                hdr_flags_reg     <= '0;
                hdr_samples_reg   <= '0;
                low_byte_hold_reg <= '0;
            end
            else
            begin
                byte_count_reg    <= byte_count_next;
                hdr_channels_reg  <= hdr_channels_next;
                hdr_flags_reg     <= hdr_flags_next;
                hdr_samples_reg   <= hdr_samples_next;
                low_byte_hold_reg <= low_byte_hold_next;
            end
        end
    end

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_buffer |=> byte_count_reg == '0 && hdr_channels_reg == '0)
        else $error("buffer state not cleared after the final beat");

    a_sample_on_odd_body_byte: assert property (@(posedge clk) disable iff (!rst_n)
        pair.sample_valid |-> byte_count_reg[0] &&
                              byte_count_reg > COUNT_W'(HEADER_BYTES))
        else $error("sample produced outside an odd body byte");

endmodule

[hdl/rpd_res_queue.sv]
// Two-entry result queue that takes up to two results a cycle and sends one when the output is ready.
// Depends on rpd_pkg and rpd_out_if.
`timescale 1ns / 1ps

module rpd_res_queue import rpd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_en,
    input  res_pair_t     pair,
    output logic [1:0]    space,
    rpd_out_if.source     out_ch
);

    res_item_t  slot_reg [2];
    res_item_t  slot_next [2];
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] kept;

    assign pop   = (count_reg != 2'd0) && out_ch.ready;
    assign kept  = count_reg - 2'(pop);
    assign space = 2'd2 - kept;

    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        count_next   = kept;
        if (pop)
            slot_next[0] = slot_reg[1];
        if (push_en && pair.sample_valid)
        begin
            slot_next[count_next[0]] = pair.sample_item;
            count_next               = count_next + 2'd1;
        end
        if (push_en && pair.status_valid)
        begin
            slot_next[count_next[0]] = pair.status_item;
            count_next               = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign out_ch.valid               = (count_reg != 2'd0);
    assign out_ch.kind                = slot_reg[0].kind;
    assign out_ch.sample              = slot_reg[0].sample;
    assign out_ch.status              = slot_reg[0].status;
    assign out_ch.channel_count       = slot_reg[0].channel_count;
    assign out_ch.per_channel_samples = slot_reg[0].per_channel_samples;
    assign out_ch.element_total       = slot_reg[0].element_total;
    assign out_ch.last                = slot_reg[0].last;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue overfilled");

    a_stall_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready && !push_en |=> count_reg == $past(count_reg))
        else $error("result queue count changed while stalled");

endmodule

[hdl/raw_pcm16_block_deframer_unit.sv]
// A result beat is offered by the result queue after its input beat has passed the input
// register and been taken. Throughput: one input beat per cycle while the queue has room;
// the output port sends one result beat per cycle while the receiver is ready, so a beat
// that closes a sample and ends the buffer occupies it for both its results.
// Reset clears the buffer state and the queues; the capacity register resets to 16384.
// Depends on rpd_pkg, rpd_if, rpd_core and rpd_res_queue.
`timescale 1ns / 1ps

module raw_pcm16_block_deframer_unit import rpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rpd_in_if.sink           in_ch,
    rpd_out_if.source        out_ch,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    logic [CAP_W-1:0] capacity_reg;
    logic             in_valid_reg;
    in_item_t         in_item_reg;
    res_pair_t        pair;
    logic [1:0]       space;
    logic [1:0]       need;
    logic             take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_wr_en)
            capacity_reg <= cfg_wr_data;
    end

    // The input register is drained as soon as the queue has room for all the
    // results that its beat produces.
    assign need  = 2'(pair.sample_valid) + 2'(pair.status_valid);
    assign take  = in_valid_reg && (need <= space);
    assign in_ch.ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.data_byte     <= in_ch.data_byte;
            in_item_reg.has_byte      <= in_ch.has_byte;
            in_item_reg.end_of_buffer <= in_ch.end_of_buffer;
        end
    end

    rpd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (in_item_reg),
        .capacity (capacity_reg),
        .pair     (pair)
    );

    rpd_res_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (take),
        .pair    (pair),
        .space   (space),
        .out_ch  (out_ch)
    );

    a_take_fits: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> need <= space)
        else $error("beat taken without room for its results");

endmodule

[test/tb_raw_pcm16_block_deframer_unit.sv]
// Self-checking testbench for raw_pcm16_block_deframer_unit: byte buffers in, samples and status out.
// A tracker class predicts every result beat and checks the block's output against it.
// Depends on rpd_pkg, rpd_if and the block itself.
`timescale 1ns / 1ps

module tb_raw_pcm16_block_deframer_unit;
    import rpd_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;

    typedef logic [7:0] byte_q_t[$];

    // Predicts the result beats of each buffer and checks the block's output against them.
    class deframe_tracker;
        logic [CAP_W-1:0] capacity;
        logic [15:0]      byte_count;
        logic [15:0]      hdr_channels;
        logic [15:0]      hdr_flags;
        logic [31:0]      hdr_samples;
        logic [7:0]       low_hold;
        logic [14:0]      elems_expected;
        res_item_t        results[$];
        int               mismatches;

        function new();
            capacity = CAP_RESET;
            mismatches = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            byte_count = '0;
            hdr_channels = '0;
            hdr_flags = '0;
            hdr_samples = '0;
            low_hold = '0;
            elems_expected = '0;
        endfunction

        function longint unsigned element_count();
            return 64'(hdr_channels) * 64'(hdr_samples);
        endfunction

        function bit header_ok();
            return hdr_channels != 0 && hdr_channels <= MAX_CHANNELS && hdr_samples != 0 &&
                   element_count() <= MAX_ELEMENTS;
        endfunction

        function bit may_emit();
            return header_ok() && hdr_flags == 0 && 64'(capacity) >= element_count();
        endfunction

        function status_t buffer_status();
            longint unsigned elems;
            longint unsigned need;
            if (byte_count < HEADER_BYTES)
                return ST_TRUNCATED;
            if (!header_ok())
                return ST_PROFILE_BOUND;
            if (hdr_flags != 0)
                return ST_UNSUPPORTED;
            elems = element_count();
            need = HEADER_BYTES + elems * 2;
            if (64'(byte_count) < need)
                return ST_TRUNCATED;
            if (64'(byte_count) > need)
                return ST_MALFORMED;
            if (64'(capacity) < elems)
                return ST_TOO_SMALL;
            return ST_OK;
        endfunction

        function void note_beat(logic [7:0] b, logic has_byte, logic end_of_buffer);
            res_item_t   item;
            int unsigned idx;
            int unsigned off;
            if (has_byte)
            begin
                idx = byte_count;
                if (idx < HEADER_BYTES)
                begin
                    if (idx < 2)
                        hdr_channels |= 16'(b) << (8 * idx);
                    else if (idx < 4)
                        hdr_flags |= 16'(b) << (8 * (idx - 2));
                    else
                        hdr_samples |= 32'(b) << (8 * (idx - 4));
                    if (idx == HEADER_BYTES - 1)
                        elems_expected = header_ok() ? 15'(element_count()) : '0;
                end
                else if (idx < COUNT_MAX)
                begin
                    off = idx - HEADER_BYTES;
                    if (off % 2 == 0)
                    begin
                        low_hold = b;
                    end
                    else if (may_emit() && (off / 2) < elems_expected)
                    begin
                        item = '0;
                        item.kind = KIND_SAMPLE;
                        item.sample = {b, low_hold};
                        item.status = ST_OK;
                        results.push_back(item);
                    end
                end
                if (byte_count < COUNT_MAX)
                    byte_count++;
            end
            if (end_of_buffer)
            begin
                item = '0;
                item.kind = KIND_STATUS;
                item.status = buffer_status();
                if (item.status == ST_OK)
                begin
                    item.channel_count = hdr_channels[3:0];
                    item.per_channel_samples = hdr_samples[14:0];
                    item.element_total = 15'(element_count());
                end
                item.last = 1'b1;
                results.push_back(item);
                clear_buffer();
            end
        endfunction

        function void check_result(res_item_t got);
            res_item_t want;
            if (results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat: kind %0d sample %0d status %0d",
                             $time, got.kind, got.sample, got.status);
                return;
            end
            want = results.pop_front();
            if (got.kind !== want.kind || got.sample !== want.sample ||
                got.status !== want.status || got.channel_count !== want.channel_count ||
                got.per_channel_samples !== want.per_channel_samples ||
                got.element_total !== want.element_total || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch", $time);
                    $display({"  expected kind %0d sample %0d status %0d ch %0d spc %0d",
                              " total %0d last %0d"},
                             want.kind, want.sample, want.status, want.channel_count,
                             want.per_channel_samples, want.element_total, want.last);
                    $display({"  actual   kind %0d sample %0d status %0d ch %0d spc %0d",
                              " total %0d last %0d"},
                             got.kind, got.sample, got.status, got.channel_count,
                             got.per_channel_samples, got.element_total, got.last);
                end
            end
        endfunction

        function int outstanding();
            return results.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    rpd_in_if  in_ch ();
    rpd_out_if out_ch ();

    raw_pcm16_block_deframer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    deframe_tracker tracker = new();

    int         snd_idle_pct = 34;
    int         rcv_idle_pct = 54;
    int         items_sent = 0;
    int         quiet_cycles = 0;
    logic [3:0] stall_req = '0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    initial
    begin
        logic [3:0] stall_seen;
        int         stall_left;
        stall_seen = '0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req != stall_seen)
            begin
                stall_seen = stall_req;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            tracker.note_beat(in_ch.data_byte, in_ch.has_byte, in_ch.end_of_buffer);
    end

    always @(posedge clk)
    begin
        res_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind = out_ch.kind;
            got.sample = out_ch.sample;
            got.status = out_ch.status;
            got.channel_count = out_ch.channel_count;
            got.per_channel_samples = out_ch.per_channel_samples;
            got.element_total = out_ch.element_total;
            got.last = out_ch.last;
            tracker.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic has_byte, input logic eob);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.has_byte <= has_byte;
        in_ch.end_of_buffer <= eob;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (has_byte || eob)
            items_sent++;
    endtask

    // Sends a buffer; the end flag rides on the last byte or on an empty closing beat.
    task automatic send_frame(input byte_q_t frame, input bit empty_end, input int noise_pct);
        for (int i = 0; i < frame.size(); i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(frame[i], 1'b1, (i == frame.size() - 1) && !empty_end);
        end
        if (empty_end || frame.size() == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic byte_q_t make_header(logic [15:0] ch, logic [15:0] fl,
                                            logic [31:0] smp);
        byte_q_t hdr;
        hdr = {ch[7:0], ch[15:8], fl[7:0], fl[15:8], smp[7:0], smp[15:8], smp[23:16],
               smp[31:24]};
        return hdr;
    endfunction

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.capacity = value;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed buffers with random content; the rest break one rule each.
    task automatic run_random(input int target);
        byte_q_t     frame;
        int unsigned pick;
        int unsigned ch;
        int unsigned fl;
        int unsigned body_len;
        int unsigned keep;
        logic [31:0] smp;
        bit          hdr_fits;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            ch = $urandom_range(1, MAX_CHANNELS);
            smp = $urandom_range(1, 24 / ch + 1);
            if ($urandom_range(39) == 0)
                smp = $urandom_range(1, 600 / ch);
            fl = 0;
            if (pick < 4)
                ch = 0;
            else if (pick < 8)
                ch = $urandom_range(MAX_CHANNELS + 1, 65535);
            else if (pick < 11)
                smp = '0;
            else if (pick < 14)
                smp = MAX_ELEMENTS / ch + $urandom_range(1, 3);
            else if (pick < 16)
                smp = $urandom | 32'h0001_0000;
            else if (pick < 21)
                fl = $urandom_range(1, 65535);
            hdr_fits = ch >= 1 && ch <= MAX_CHANNELS && smp != 0 &&
                       64'(ch) * 64'(smp) <= MAX_ELEMENTS;
            body_len = hdr_fits ? 2 * ch * smp : $urandom_range(0, 10);
            if (pick >= 21 && pick < 26)
                body_len = $urandom_range(0, body_len - 1);
            else if (pick >= 26 && pick < 30)
                body_len += $urandom_range(1, 5);
            frame = make_header(16'(ch), 16'(fl), smp);
            if (pick >= 30 && pick < 33)
            begin
                keep = $urandom_range(0, HEADER_BYTES - 1);
                while (frame.size() > keep)
                    void'(frame.pop_back());
                body_len = 0;
            end
            else if (pick >= 33 && pick < 36)
            begin
                frame.delete();
                body_len = $urandom_range(0, 40);
            end
            repeat (body_len) frame.push_back(8'($urandom));
            send_frame(frame, $urandom_range(4) == 0, 4);
        end
    endtask

    initial
    begin
        byte_q_t frame;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.has_byte <= 1'b0;
        in_ch.end_of_buffer <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity(CAP_RESET);
        // A beat with neither byte nor end does nothing; an empty closing beat alone is truncated.
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // Extreme samples, the second closing the buffer in the same beat as its high byte.
        frame = make_header(16'd1, 16'd0, 32'd2);
        frame.push_back(8'h00);
        frame.push_back(8'h80);
        frame.push_back(8'hFF);
        frame.push_back(8'h7F);
        send_frame(frame, 1'b0, 0);
        // Nonzero flags, ending on the last header byte.
        frame = make_header(16'd2, 16'h8001, 32'd1);
        send_frame(frame, 1'b0, 0);
        run_random(700);

        drain_results();
        snd_idle_pct = 54;
        rcv_idle_pct = 34;
        write_capacity('0);
        run_random(1000);

        drain_results();
        write_capacity(CAP_W'($urandom_range(1, 40)));
        run_random(1500);

        drain_results();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_capacity(CAP_RESET);
        // The receiver holds off while buffers keep coming, so the block fills and stalls.
        stall_req <= stall_req + 4'd1;
        run_random(2000);

        drain_results();
        if (tracker.outstanding() != 0)
            $display("%0d expected results never arrived", tracker.outstanding());
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/rpd_pkg.sv
hdl/rpd_if.sv
hdl/rpd_core.sv
hdl/rpd_res_queue.sv
hdl/raw_pcm16_block_deframer_unit.sv
test/tb_raw_pcm16_block_deframer_unit.sv
